/* rtl/fpl_pkg.sv */
// package for the free-list pool: pool size, index width, action codes and
// the memory word layout. no dependencies.
`timescale 1ns / 1ps

package fpl_pkg;

  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned IDX_W     = $clog2(POOL_SIZE + 1);
  localparam int unsigned ACT_W     = 3;

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LINK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RING   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REINIT = 3'd4;

  // one entry of the pool memory: free-list link, ring up and ring down
  typedef struct packed {
    logic [IDX_W-1:0] fn;
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] dn;
  } word_t;

  // per-field write enables
  typedef struct packed {
    logic fn;
    logic up;
    logic dn;
  } wr_en_t;

endpackage

/* rtl/free_list_pool_with_rings.sv */
// free-list pool allocator with circular rings; all links in one memory
// with per-field write enables. depends on fpl_pkg.
//
// channel | direction | handshake            | payload
// input   | in        | in_valid_i/in_ready_o | action_i, entry_i, new_entry_i
// result  | out       | out_valid_o/out_ready_i | ok_o, given_entry_o, free_count_o,
//         |           |                      | high_water_o, available_o, freed_count_o
//
// one transaction at a time; ready only while idle, a held result does not block input
// allocate and free: S_ALLOC or S_FREE; link-after: S_LNK1, S_LNK2, S_LNK3; unused codes: S_FIN
// ring free: a memory read then write-back of each member entry (S_RF_RD, S_RF_PROC)
// reinit: one write per rebuilt entry, plus one to clear the last pool
// entry when the rebuild stops short of it
// after reset a clearing pass writes every entry, 0 through POOL_SIZE, and rebuilds the memory
// a stalled result keeps the next one in its final state until the edge that takes it
`timescale 1ns / 1ps

module free_list_pool_with_rings (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fpl_pkg::ACT_W-1:0] action_i,
  input  logic [fpl_pkg::IDX_W-1:0] entry_i,
  input  logic [fpl_pkg::IDX_W-1:0] new_entry_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      ok_o,
  output logic [fpl_pkg::IDX_W-1:0] given_entry_o,
  output logic [fpl_pkg::IDX_W-1:0] free_count_o,
  output logic [fpl_pkg::IDX_W-1:0] high_water_o,
  output logic                      available_o,
  output logic [fpl_pkg::IDX_W-1:0] freed_count_o
);

  localparam int unsigned W = fpl_pkg::IDX_W;
  localparam logic [W-1:0] POOL = W'(fpl_pkg::POOL_SIZE);
  localparam logic [W-1:0] ONE  = W'(1);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ALLOC   = 4'd2;
  localparam logic [3:0] S_FREE    = 4'd3;
  localparam logic [3:0] S_LNK1    = 4'd4;
  localparam logic [3:0] S_LNK2    = 4'd5;
  localparam logic [3:0] S_LNK3    = 4'd6;
  localparam logic [3:0] S_RF_RD   = 4'd7;
  localparam logic [3:0] S_RF_PROC = 4'd8;
  localparam logic [3:0] S_RI      = 4'd9;
  localparam logic [3:0] S_RI_END  = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  fpl_pkg::word_t mem_q [0:fpl_pkg::POOL_SIZE];
  fpl_pkg::word_t rd_q;
  fpl_pkg::word_t wr_word;
  fpl_pkg::wr_en_t wr_en;
  logic [W-1:0] wr_addr, rd_addr;
  logic rd_en;

  logic [3:0] state_q, state_d;
  logic [W-1:0] head_q, head_d, left_q, left_d, top_q, top_d;
  logic avail_q, avail_d;
  logic [W-1:0] ptr_q, ptr_d, ref_q, ref_d, tgt_q, tgt_d;
  logic ok_q, ok_d;
  logic [W-1:0] given_q, given_d, freed_q, freed_d;
  logic out_valid_q, out_valid_d;
  logic out_ok_q;
  logic [W-1:0] out_given_q, out_left_q, out_top_q, out_freed_q;
  logic out_avail_q;
  logic finish, out_load, accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    left_d  = left_q;
    top_d   = top_q;
    avail_d = avail_q;
    ptr_d   = ptr_q;
    ref_d   = ref_q;
    tgt_d   = tgt_q;
    ok_d    = ok_q;
    given_d = given_q;
    freed_d = freed_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = '0;
    wr_addr = ptr_q;
    wr_word = '0;
    finish  = 1'b0;

    unique case (state_q)
      S_CLR: begin
        wr_en   = '{fn: 1'b1, up: 1'b1, dn: 1'b1};
        wr_word.fn = (ptr_q == POOL) ? '0 : ptr_q + ONE;
        if (ptr_q == POOL) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + ONE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ok_d    = 1'b1;
          given_d = '0;
          freed_d = '0;
          state_d = S_FIN;
          unique case (action_i)
            fpl_pkg::ACT_ALLOC: begin
              rd_en   = 1'b1;
              rd_addr = head_q;
              state_d = S_ALLOC;
            end
            fpl_pkg::ACT_FREE: begin
              if (entry_i != '0 && entry_i <= POOL) begin
                ptr_d   = entry_i;
                state_d = S_FREE;
              end
            end
            fpl_pkg::ACT_LINK: begin
              if (entry_i <= POOL && new_entry_i <= POOL) begin
                rd_en   = 1'b1;
                rd_addr = entry_i;
                ptr_d   = entry_i;
                ref_d   = new_entry_i;
                state_d = S_LNK1;
              end
            end
            fpl_pkg::ACT_RING: begin
              if (entry_i != '0 && entry_i <= POOL) begin
                rd_en   = 1'b1;
                rd_addr = entry_i;
                ptr_d   = entry_i;
                ref_d   = entry_i;
                state_d = S_RF_PROC;
              end
            end
            fpl_pkg::ACT_REINIT: begin
              ptr_d   = ONE;
              ref_d   = (top_q == POOL) ? POOL : top_q + ONE;
              state_d = S_RI;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_ALLOC: begin
        given_d = head_q;
        if (rd_q.fn == '0) begin
          avail_d = 1'b0;
          ok_d    = 1'b0;
        end else begin
          head_d  = rd_q.fn;
          if (head_q > top_q) begin
            top_d = head_q;
          end
          wr_en   = '{fn: 1'b1, up: 1'b1, dn: 1'b1};
          wr_addr = head_q;
          left_d  = (left_q != '0) ? left_q - ONE : left_q;
        end
        finish = 1'b1;
      end
      S_FREE: begin
        wr_en      = '{fn: 1'b1, up: 1'b1, dn: 1'b1};
        wr_word.fn = head_q;
        head_d     = ptr_q;
        avail_d    = 1'b1;
        left_d     = (left_q < POOL) ? left_q + ONE : left_q;
        freed_d    = ONE;
        finish     = 1'b1;
      end
      S_LNK1: begin
        // new entry takes the anchor's old successor and points back to the anchor
        wr_en      = '{fn: 1'b0, up: 1'b1, dn: 1'b1};
        wr_addr    = ref_q;
        wr_word.dn = rd_q.dn;
        wr_word.up = ptr_q;
        tgt_d      = (ptr_q == ref_q) ? ref_q : rd_q.dn;
        state_d    = S_LNK2;
      end
      S_LNK2: begin
        wr_en      = '{fn: 1'b0, up: 1'b0, dn: 1'b1};
        wr_addr    = ptr_q;
        wr_word.dn = ref_q;
        state_d    = S_LNK3;
      end
      S_LNK3: begin
        wr_en      = '{fn: 1'b0, up: 1'b1, dn: 1'b0};
        wr_addr    = tgt_q;
        wr_word.up = ref_q;
        finish     = 1'b1;
      end
      S_RF_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_q;
        state_d = S_RF_PROC;
      end
      S_RF_PROC: begin
        wr_en      = '{fn: 1'b1, up: 1'b1, dn: 1'b1};
        wr_word.fn = head_q;
        head_d     = ptr_q;
        avail_d    = 1'b1;
        left_d     = (left_q < POOL) ? left_q + ONE : left_q;
        freed_d    = freed_q + ONE;
        ptr_d      = rd_q.dn;
        // stop back at the start, on a null link, or once the whole pool is out
        if (rd_q.dn == ref_q || rd_q.dn == '0 || freed_d == POOL) begin
          finish = 1'b1;
        end else begin
          state_d = S_RF_RD;
        end
      end
      S_RI: begin
        wr_en      = '{fn: 1'b1, up: 1'b0, dn: 1'b0};
        wr_word.fn = (ptr_q == POOL) ? '0 : ptr_q + ONE;
        if (ptr_q == ref_q) begin
          if (ref_q == POOL) begin
            head_d = ONE;
            top_d  = '0;
            left_d = POOL;
            finish = 1'b1;
          end else begin
            state_d = S_RI_END;
          end
        end else begin
          ptr_d = ptr_q + ONE;
        end
      end
      S_RI_END: begin
        wr_en   = '{fn: 1'b1, up: 1'b0, dn: 1'b0};
        wr_addr = POOL;
        head_d  = ONE;
        top_d   = '0;
        left_d  = POOL;
        finish  = 1'b1;
      end
      S_FIN: begin
        finish = 1'b1;
      end
      default: state_d = S_CLR;
    endcase

    out_load = finish && (!out_valid_q || out_ready_i);
    if (out_load) begin
      state_d = S_IDLE;
    end else if (finish) begin
      state_d = S_FIN;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      head_q      <= ONE;
      left_q      <= POOL;
      top_q       <= '0;
      avail_q     <= 1'b1;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      left_q      <= left_d;
      top_q       <= top_d;
      avail_q     <= avail_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q   <= ref_d;
    tgt_q   <= tgt_d;
    ok_q    <= ok_d;
    given_q <= given_d;
    freed_q <= freed_d;
    if (out_load) begin
      out_ok_q    <= ok_d;
      out_given_q <= given_d;
      out_left_q  <= left_d;
      out_top_q   <= top_d;
      out_avail_q <= avail_d;
      out_freed_q <= freed_d;
    end
  end

  // pool memory: one registered read port, one write port with field enables
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (wr_en.fn) begin
      mem_q[wr_addr].fn <= wr_word.fn;
    end
    if (wr_en.up) begin
      mem_q[wr_addr].up <= wr_word.up;
    end
    if (wr_en.dn) begin
      mem_q[wr_addr].dn <= wr_word.dn;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign given_entry_o = out_given_q;
  assign free_count_o  = out_left_q;
  assign high_water_o  = out_top_q;
  assign available_o   = out_avail_q;
  assign freed_count_o = out_freed_q;

endmodule

/* rtl/fpl_checker.sv */
// port-level checks for the free-list pool, attached to the top level by bind.
// depends on fpl_pkg.
`timescale 1ns / 1ps

module fpl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic [fpl_pkg::ACT_W-1:0] action_i,
  input logic [fpl_pkg::IDX_W-1:0] entry_i,
  input logic [fpl_pkg::IDX_W-1:0] new_entry_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      ok_o,
  input logic [fpl_pkg::IDX_W-1:0] given_entry_o,
  input logic [fpl_pkg::IDX_W-1:0] free_count_o,
  input logic [fpl_pkg::IDX_W-1:0] high_water_o,
  input logic                      available_o,
  input logic [fpl_pkg::IDX_W-1:0] freed_count_o
);

  localparam logic [fpl_pkg::IDX_W-1:0] POOL = fpl_pkg::IDX_W'(fpl_pkg::POOL_SIZE);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(given_entry_o) && $stable(free_count_o) && $stable(freed_count_o))
    else $error("result changed while stalled");

  // a failed allocation releases nothing and clears the available flag
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> freed_count_o == '0 && !available_o)
    else $error("failed allocation with released entries or flag set");

  // any release sets the available flag
  a_freed_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && freed_count_o != '0 |-> available_o && ok_o)
    else $error("entries released but flag clear");

  // counters stay within the pool
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_count_o <= POOL && high_water_o <= POOL
      && freed_count_o <= POOL && given_entry_o <= POOL)
    else $error("counter beyond pool size");

endmodule

bind free_list_pool_with_rings fpl_checker u_fpl_checker (.*);
